// ===== design/bfr_pkg.sv =====
// Shared types and constants for the binary frame receiver.
package bfr_pkg;

   localparam logic [7:0]  SYNC_FIRST         = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND        = 8'h62;
   localparam logic [19:0] DEFAULT_POLL_LIMIT = 20'd100000;

   localparam int ITEM_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH  = 4;

   localparam logic       OP_IDLE = 1'b0;
   localparam logic       OP_BYTE = 1'b1;

   localparam logic       KIND_PAYLOAD = 1'b0;
   localparam logic       KIND_STATUS  = 1'b1;

   localparam logic [1:0] STATUS_VALID    = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_length;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

endpackage

// ===== design/bfr_fifo.sv =====
// Small synchronous queue used between the front, the frame engine and the result port.
module bfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/bfr_frame_engine.sv =====
// Frame engine: sync hunt, header capture, payload emission, checksum and timeout.
module bfr_frame_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic [19:0]       poll_limit,
   input  logic              item_valid,
   input  bfr_pkg::item_type item,
   output logic              item_take,
   input  logic              rsp_full,
   output logic              rsp_push,
   output bfr_pkg::rsp_type  rsp
);
   import bfr_pkg::*;

   localparam logic [1:0] PH_HUNT   = 2'd0;
   localparam logic [1:0] PH_SYNC2  = 2'd1;
   localparam logic [1:0] PH_HEADER = 2'd2;
   localparam logic [1:0] PH_BODY   = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  hdr_pos_ff, hdr_pos_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [16:0] body_count_ff, body_count_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  rx_sum_a_ff, rx_sum_a_in;
   logic [19:0] poll_count_ff, poll_count_in;

   logic        done;
   logic        emit;
   logic        timeout;
   logic        rearm;
   logic [1:0]  done_status;
   logic [7:0]  sum_a_add;
   logic [7:0]  b;

   assign item_take = item_valid && !rsp_full;
   assign b         = item.rx_byte;
   assign sum_a_add = sum_a_ff + b;
   assign timeout   = ({1'b0, poll_count_ff} + 21'd1) >= {1'b0, poll_limit};

   always_comb begin
      phase_in      = phase_ff;
      hdr_pos_in    = hdr_pos_ff;
      class_in      = class_ff;
      id_in         = id_ff;
      length_in     = length_ff;
      body_count_in = body_count_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      rx_sum_a_in   = rx_sum_a_ff;
      done          = 1'b0;
      emit          = 1'b0;
      done_status   = STATUS_VALID;

      if (item.op == OP_BYTE) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (b == SYNC_FIRST) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (b == SYNC_SECOND) begin
                  phase_in   = PH_HEADER;
                  hdr_pos_in = '0;
                  sum_a_in   = '0;
                  sum_b_in   = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_HEADER: begin
               sum_a_in   = sum_a_add;
               sum_b_in   = sum_b_ff + sum_a_add;
               hdr_pos_in = hdr_pos_ff + 2'd1;
               unique case (hdr_pos_ff)
                  2'd0: class_in = b;
                  2'd1: id_in = b;
                  2'd2: length_in = {8'd0, b};
                  default: begin
                     length_in     = {b, length_ff[7:0]};
                     phase_in      = PH_BODY;
                     body_count_in = '0;
                  end
               endcase
            end
            default: begin
               priority if (body_count_ff < {1'b0, length_ff}) begin
                  sum_a_in = sum_a_add;
                  sum_b_in = sum_b_ff + sum_a_add;
                  emit     = 1'b1;
               end else if (body_count_ff == {1'b0, length_ff}) begin
                  rx_sum_a_in = b;
               end else begin
                  done        = 1'b1;
                  done_status = (rx_sum_a_ff == sum_a_ff && b == sum_b_ff)
                                ? STATUS_VALID : STATUS_BAD_SUM;
               end
               body_count_in = body_count_ff + 17'd1;
            end
         endcase
      end

      rearm         = done || timeout;
      poll_count_in = poll_count_ff + 20'd1;

      rsp.kind           = KIND_STATUS;
      rsp.payload_byte   = '0;
      rsp.msg_class      = class_in;
      rsp.msg_id         = id_in;
      rsp.payload_length = length_in;
      rsp.status         = done ? done_status : STATUS_TIMEOUT;
      rsp.last           = 1'b1;
      if (!rearm) begin
         rsp.kind         = KIND_PAYLOAD;
         rsp.payload_byte = b;
         rsp.status       = STATUS_VALID;
         rsp.last         = 1'b0;
      end
      rsp_push = item_take && (rearm || emit);
   end

   always_ff @(posedge clock) begin
      if (reset || (item_take && rearm)) begin
         phase_ff      <= PH_HUNT;
         hdr_pos_ff    <= '0;
         class_ff      <= '0;
         id_ff         <= '0;
         length_ff     <= '0;
         body_count_ff <= '0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         rx_sum_a_ff   <= '0;
         poll_count_ff <= '0;
      end else if (item_take) begin
         phase_ff      <= phase_in;
         hdr_pos_ff    <= hdr_pos_in;
         class_ff      <= class_in;
         id_ff         <= id_in;
         length_ff     <= length_in;
         body_count_ff <= body_count_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         rx_sum_a_ff   <= rx_sum_a_in;
         poll_count_ff <= poll_count_in;
      end
   end

endmodule

// ===== design/binary_frame_receiver.sv =====
// Binary frame receiver top level: poll queue, frame engine and result queue.
// A poll is registered in the poll queue; its result is registered in the result queue.
// Throughput: one poll per cycle by the frame engine, while the result queue is not full.
// Either side may stall alone; the poll queue and result queue absorb up to their depths.
// Reset: synchronous, active high; empties both queues, rearms the engine, limit to 100000.
module binary_frame_receiver #(
   parameter int ITEM_DEPTH = bfr_pkg::ITEM_QUEUE_DEPTH,
   parameter int RSP_DEPTH  = bfr_pkg::RSP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_op,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_msg_class,
   output logic [7:0]  rsp_msg_id,
   output logic [15:0] rsp_payload_length,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [19:0] csr_write_data
);
   import bfr_pkg::*;

   logic [19:0] poll_limit_ff;
   item_type    req_item;
   item_type    item_head;
   logic        item_empty;
   logic        item_take;
   rsp_type     eng_rsp;
   rsp_type     rsp_head;
   logic        eng_push;
   logic        rsp_q_full;

   assign req_item.op      = req_op;
   assign req_item.rx_byte = req_rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= DEFAULT_POLL_LIMIT;
      end else if (csr_write_enable) begin
         poll_limit_ff <= csr_write_data;
      end
   end

   bfr_fifo #(
      .WIDTH($bits(item_type)),
      .DEPTH(ITEM_DEPTH)
   ) u_item_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(req_item),
      .full     (full),
      .pop      (item_take),
      .pop_data (item_head),
      .empty    (item_empty)
   );

   bfr_frame_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .poll_limit(poll_limit_ff),
      .item_valid(!item_empty),
      .item      (item_head),
      .item_take (item_take),
      .rsp_full  (rsp_q_full),
      .rsp_push  (eng_push),
      .rsp       (eng_rsp)
   );

   bfr_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (eng_push),
      .push_data(eng_rsp),
      .full     (rsp_q_full),
      .pop      (pop),
      .pop_data (rsp_head),
      .empty    (empty)
   );

   assign rsp_kind           = rsp_head.kind;
   assign rsp_payload_byte   = rsp_head.payload_byte;
   assign rsp_msg_class      = rsp_head.msg_class;
   assign rsp_msg_id         = rsp_head.msg_id;
   assign rsp_payload_length = rsp_head.payload_length;
   assign rsp_status         = rsp_head.status;
   assign rsp_last           = rsp_head.last;

endmodule

// ===== design/bfr_checker.sv =====
// Port-level checks for the binary frame receiver, bound to the top level.
module bfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        rsp_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);
   import bfr_pkg::*;

   assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_last == (rsp_kind == KIND_STATUS)))
      else $error("last does not match result kind");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == KIND_PAYLOAD) |-> (rsp_status == STATUS_VALID))
      else $error("payload transaction carries a status");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == KIND_STATUS) |->
      (rsp_payload_byte == 8'd0 && rsp_status != 2'd3))
      else $error("malformed status transaction");

endmodule

bind binary_frame_receiver bfr_checker u_bfr_checker (
   .clock           (clock),
   .reset           (reset),
   .full            (full),
   .empty           (empty),
   .rsp_kind        (rsp_kind),
   .rsp_payload_byte(rsp_payload_byte),
   .rsp_status      (rsp_status),
   .rsp_last        (rsp_last)
);
